// ===== hw/rtl/atlb_pkg.sv =====
// Shared types and constants for the associative translation buffer.
package atlb_pkg;

    localparam int ENTRIES     = 16;
    localparam int TIME_BITS   = 32;
    localparam int SLOT_BITS   = $clog2(ENTRIES);
    localparam int TREE        = 1 << SLOT_BITS;
    localparam int LVL_BITS    = $clog2(SLOT_BITS + 1);
    localparam int QDEPTH      = 2;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCNT_BITS   = $clog2(QDEPTH + 1);
    localparam int PAGE_BITS   = 16;
    localparam int FRAME_BITS  = 16;
    localparam int ATIME_BITS  = 32;
    localparam int RSLOT_BITS  = 4;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_INVAL  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [PAGE_BITS-1:0]  virtual_page;
        logic [FRAME_BITS-1:0] frame_in;
        logic [ATIME_BITS-1:0] access_time;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_out;
        logic [RSLOT_BITS-1:0] entry_slot;
    } rsp_t;

    typedef struct packed {
        op_t                   op;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
        logic [TIME_BITS-1:0]  now;
    } cmd_t;

endpackage

// ===== hw/rtl/atlb_if.sv =====
// Request and response channel interfaces.
interface atlb_req_if import atlb_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface atlb_rsp_if import atlb_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/assoc_tlb_rr_lru_unit.sv =====
// Fully associative translation buffer, top level.
// Fully associative translation buffer of 16 entries with round-robin or LRU
// replacement selected by the one configuration bit (0 round robin, 1 LRU).
// Requests are decoded by the front end into a two-entry command queue, so
// requests keep being accepted, while the queue has room, as the back end
// works or a response waits. The back end handles one command at a time,
// through compare, decide and response states for a lookup, invalidate,
// or an insert that finds a free slot or uses round robin; an LRU insert
// into a full table adds tree and fill states, where the oldest stamp is
// found by a registered pairwise minimum, one level a cycle. The response
// register holds a response until it is taken.
module assoc_tlb_rr_lru_unit import atlb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    atlb_req_if.sink   req,
    atlb_rsp_if.source rsp
);

    logic full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;

    atlb_front u_front (
        .req      (req),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    atlb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .out_valid (q_valid),
        .out_cmd   (q_cmd)
    );

    atlb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (pop),
        .rsp       (rsp)
    );

endmodule

// ===== hw/rtl/atlb_front.sv =====
// Front end: accept requests, decode them into commands for the queue.
module atlb_front import atlb_pkg::*; (
    atlb_req_if.sink req,
    input  logic     full,
    output logic     push,
    output cmd_t     push_cmd
);

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        push_cmd.op    = op_t'(req.data.opcode);
        push_cmd.page  = req.data.virtual_page;
        push_cmd.frame = (op_t'(req.data.opcode) == OP_INSERT) ? req.data.frame_in : '0;
        push_cmd.now   = TIME_BITS'(req.data.access_time);
    end

endmodule

// ===== hw/rtl/atlb_queue.sv =====
// Short command queue between front and back.
module atlb_queue import atlb_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic out_valid,
    output cmd_t out_cmd
);

    cmd_t                 store_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] cnt_reg;
    logic [QCNT_BITS-1:0] cnt_next;

    assign full      = (cnt_reg == QCNT_BITS'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = store_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(pop && out_valid))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && pop && out_valid)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && out_valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");
`endif

endmodule

// ===== hw/rtl/atlb_back.sv =====
// Back end: entry table, match, victim choice, LRU search and response register.
module atlb_back import atlb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    atlb_rsp_if.source rsp
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CMP    = 6'b000010,
        S_DECIDE = 6'b000100,
        S_TREE   = 6'b001000,
        S_FILL   = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  policy_reg;
    cmd_t                  cmd_reg;
    logic [ENTRIES-1:0]    valid_reg;
    logic [PAGE_BITS-1:0]  page_reg  [ENTRIES];
    logic [FRAME_BITS-1:0] frame_reg [ENTRIES];
    logic [TIME_BITS-1:0]  stamp_reg [ENTRIES];
    logic [SLOT_BITS-1:0]  rr_reg;
    logic [ENTRIES-1:0]    match_reg;
    logic [ENTRIES-1:0]    free_reg;
    logic [TIME_BITS-1:0]  cand_stamp_reg [TREE];
    logic [SLOT_BITS-1:0]  cand_idx_reg   [TREE];
    logic [LVL_BITS-1:0]   lvl_reg;
    rsp_t                  res_reg;
    rsp_t                  res_next;
    logic [SLOT_BITS-1:0]  res_idx_reg;
    logic [SLOT_BITS-1:0]  res_idx_next;
    logic                  out_valid_reg;
    rsp_t                  out_data_reg;

    logic                  hit_any;
    logic                  free_any;
    logic [SLOT_BITS-1:0]  hit_idx;
    logic [SLOT_BITS-1:0]  free_idx;
    logic                  ent_we;
    logic [SLOT_BITS-1:0]  ent_idx;
    logic                  stamp_we;
    logic [SLOT_BITS-1:0]  stamp_idx;
    logic                  inval;
    logic                  rr_adv;
    logic                  out_load;

    function automatic logic [SLOT_BITS-1:0] first_set(input logic [ENTRIES-1:0] v);
        logic [SLOT_BITS-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = SLOT_BITS'(i);
            end
        end
        return idx;
    endfunction

    assign hit_any  = |match_reg;
    assign free_any = |free_reg;
    assign hit_idx  = first_set(match_reg);
    assign free_idx = first_set(free_reg);
    assign out_load = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next   = state_reg;
        q_pop        = 1'b0;
        ent_we       = 1'b0;
        ent_idx      = free_idx;
        stamp_we     = 1'b0;
        stamp_idx    = hit_idx;
        inval        = 1'b0;
        rr_adv       = 1'b0;
        res_next     = res_reg;
        res_idx_next = res_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                res_next     = '0;
                res_idx_next = '0;
                state_next   = S_RESP;
                unique case (cmd_reg.op)
                    OP_LOOKUP:
                    begin
                        if (hit_any)
                        begin
                            res_next.hit        = 1'b1;
                            res_next.frame_out  = frame_reg[hit_idx];
                            res_next.entry_slot = RSLOT_BITS'(hit_idx);
                            res_idx_next        = hit_idx;
                            stamp_we            = policy_reg;
                            stamp_idx           = hit_idx;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (free_any || !policy_reg)
                        begin
                            ent_we = 1'b1;
                            if (free_any)
                            begin
                                ent_idx = free_idx;
                            end
                            else
                            begin
                                ent_idx = rr_reg;
                                rr_adv  = 1'b1;
                            end
                            stamp_we            = policy_reg;
                            stamp_idx           = ent_idx;
                            res_next.entry_slot = RSLOT_BITS'(ent_idx);
                            res_idx_next        = ent_idx;
                        end
                        else
                        begin
                            state_next = S_TREE;
                        end
                    end
                    OP_INVAL:
                    begin
                        inval = 1'b1;
                    end
                    OP_NOP:
                    begin
                        inval = 1'b0;
                    end
                    default:
                    begin
                        inval = 1'b0;
                    end
                endcase
            end
            S_TREE:
            begin
                if (lvl_reg == LVL_BITS'(SLOT_BITS - 1))
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                ent_we              = 1'b1;
                ent_idx             = cand_idx_reg[0];
                stamp_we            = 1'b1;
                stamp_idx           = cand_idx_reg[0];
                res_next.entry_slot = RSLOT_BITS'(cand_idx_reg[0]);
                res_idx_next        = cand_idx_reg[0];
                state_next          = S_RESP;
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= 1'b0;
            valid_reg     <= '0;
            rr_reg        <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            if (inval)
            begin
                valid_reg <= valid_reg & ~match_reg;
            end
            else if (ent_we)
            begin
                valid_reg[ent_idx] <= 1'b1;
            end
            if (stamp_we)
            begin
                stamp_reg[stamp_idx] <= cmd_reg.now;
            end
            if (rr_adv)
            begin
                rr_reg <= (rr_reg == SLOT_BITS'(ENTRIES - 1)) ? '0 : rr_reg + 1'b1;
            end
            if (state_reg == S_CMP)
            begin
                lvl_reg <= '0;
            end
            else if (state_reg == S_TREE)
            begin
                lvl_reg <= lvl_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (ent_we)
        begin
            page_reg[ent_idx]  <= cmd_reg.page;
            frame_reg[ent_idx] <= cmd_reg.frame;
        end
        if (state_reg == S_CMP)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                match_reg[i] <= valid_reg[i] && (page_reg[i] == cmd_reg.page);
            end
            free_reg <= ~valid_reg;
            for (int i = 0; i < TREE; i++)
            begin
                cand_idx_reg[i] <= SLOT_BITS'(i);
                if (i < ENTRIES)
                begin
                    cand_stamp_reg[i] <= stamp_reg[i];
                end
                else
                begin
                    cand_stamp_reg[i] <= '1;
                end
            end
        end
        else if (state_reg == S_TREE)
        begin
            for (int k = 0; k < TREE / 2; k++)
            begin
                if (cand_stamp_reg[2*k+1] < cand_stamp_reg[2*k])
                begin
                    cand_stamp_reg[k] <= cand_stamp_reg[2*k+1];
                    cand_idx_reg[k]   <= cand_idx_reg[2*k+1];
                end
                else
                begin
                    cand_stamp_reg[k] <= cand_stamp_reg[2*k];
                    cand_idx_reg[k]   <= cand_idx_reg[2*k];
                end
            end
        end
        res_reg     <= res_next;
        res_idx_reg <= res_idx_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

`ifndef SYNTHESIS
    a_rr_range: assert property (@(posedge clk) disable iff (!rst_n)
        rr_reg <= SLOT_BITS'(ENTRIES - 1))
        else $error("round robin pointer out of range");

    a_inval_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && cmd_reg.op == OP_INVAL) |=> ((valid_reg & match_reg) == '0))
        else $error("invalidate left a matching entry valid");

    a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && cmd_reg.op == OP_INSERT) |-> valid_reg[res_idx_reg])
        else $error("inserted slot not valid");
`endif

endmodule
